// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

  // Operation codes carried in the op field of an input item.
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_BACK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Kinds of whole-screen walk done by the datapath sweep counter.
  typedef enum logic [1:0] {
    SW_INIT   = 2'd0,
    SW_CLEAR  = 2'd1,
    SW_SCROLL = 2'd2
  } sweep_e;

  // Special character codes.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Reset values of the color register and of every screen cell.
  localparam logic [7:0]  COLOR_RESET = 8'h0F;
  localparam logic [15:0] BLANK_RESET = 16'h0F20;

  // Input item transaction payload.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  // Result item transaction payload.
  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
    logic [15:0] cell_entry;
  } out_item_t;

  // Configuration transaction payload.
  typedef logic [7:0] color_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   cur_home;
    logic   put_exec;
    logic   sweep_start;
    sweep_e sweep_kind;
    logic   sweep_step;
    logic   bs_begin;
    logic   rd_cursor;
    logic   scan_dec;
    logic   bs_fix;
    logic   erase;
    logic   rd_cell;
    logic   resp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       put_ovf;
    logic       bs_scan;
    logic       scan_space;
    logic       col_is_one;
    logic       sweep_last;
    logic       out_free;
  } status_t;

endpackage

// ===== hw/rtl/tcw_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface tcw_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_INIT     = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_DISPATCH = 12'b0000_0000_0100,
    S_PUT      = 12'b0000_0000_1000,
    S_SWEEP    = 12'b0000_0001_0000,
    S_BACK     = 12'b0000_0010_0000,
    S_BS_RD    = 12'b0000_0100_0000,
    S_BS_CHK   = 12'b0000_1000_0000,
    S_BS_FIX   = 12'b0001_0000_0000,
    S_BS_WR    = 12'b0010_0000_0000,
    S_READ     = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.op)
          OP_PUT:  state_d = S_PUT;
          OP_BACK: state_d = S_BACK;
          OP_CLEAR: begin
            cmd_o.cur_home    = 1'b1;
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = SW_CLEAR;
            state_d           = S_SWEEP;
          end
          OP_READ: state_d = S_READ;
          default: state_d = S_RESP;
        endcase
      end
      S_PUT: begin
        cmd_o.put_exec = 1'b1;
        if (status_i.put_ovf) begin
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_kind  = SW_SCROLL;
          state_d           = S_SWEEP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_RESP;
        end
      end
      S_BACK: begin
        cmd_o.bs_begin = 1'b1;
        state_d = status_i.bs_scan ? S_BS_RD : S_BS_WR;
      end
      S_BS_RD: begin
        cmd_o.rd_cursor = 1'b1;
        state_d         = S_BS_CHK;
      end
      S_BS_CHK: begin
        // Keep stepping left over spaces, but never look at column zero.
        if (status_i.scan_space) begin
          cmd_o.scan_dec = 1'b1;
          state_d = status_i.col_is_one ? S_BS_FIX : S_BS_RD;
        end else begin
          state_d = S_BS_FIX;
        end
      end
      S_BS_FIX: begin
        cmd_o.bs_fix = 1'b1;
        state_d      = S_BS_WR;
      end
      S_BS_WR: begin
        cmd_o.erase = 1'b1;
        state_d     = S_RESP;
      end
      S_READ: begin
        cmd_o.rd_cell = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register; reset starts the screen initialization pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only loaded when the output register can take it.
  a_resp_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resp_load |-> status_i.out_free)
    else $error("result loaded while output register is occupied");

  // No new item is taken while a sweep is still walking the screen.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !cmd_o.sweep_step)
    else $error("item accepted during a sweep");

  // A scroll sweep is started only by a put that runs past the bottom row.
  a_scroll_from_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sweep_start && cmd_o.sweep_kind == SW_SCROLL) |->
      (cmd_o.put_exec && status_i.put_ovf))
    else $error("scroll started without a put overflow");

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      cfg_valid_i,
  input  color_t    cfg_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  cmd_t      cmd_i,
  output status_t   status_o
);

  localparam int Cells = ROWS * COLS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(Cells);

  localparam logic [CW:0]   ColsW    = (CW+1)'(COLS);
  localparam logic [RW:0]   RowsW    = (RW+1)'(ROWS);
  localparam logic [CW-1:0] LastCol  = CW'(COLS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
  localparam logic [AW-1:0] ColsA    = AW'(COLS);
  localparam logic [AW-1:0] LastA    = AW'(Cells - 1);
  localparam logic [AW-1:0] CopyEndA = AW'(Cells - COLS);

  // Screen buffer, one write and one registered read per cycle.
  logic [15:0]   mem_q [Cells];
  logic [15:0]   rdata_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data;

  in_item_t      item_q;
  color_t        color_q;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic          scr_q;

  sweep_e        sw_kind_q;
  logic [AW-1:0] idx_q;
  logic          pend_q;
  logic          pcopy_q;
  logic [AW-1:0] pidx_q;

  logic          out_valid_q;
  out_item_t     out_item_q;

  logic [AW-1:0] cur_addr, item_addr;
  logic          in_range;
  logic          copy_rd;
  logic [15:0]   blank;
  logic [CW:0]   put_col;
  logic [RW:0]   put_row;
  logic          put_plain, put_ovf;

  assign cur_addr  = AW'(cur_row_q) * ColsA + AW'(cur_col_q);
  assign item_addr = AW'(item_q.row) * ColsA + AW'(item_q.col);
  assign in_range  = (int'(item_q.row) < ROWS) && (int'(item_q.col) < COLS);
  assign copy_rd   = cmd_i.sweep_step && (sw_kind_q == SW_SCROLL) && (idx_q < CopyEndA);
  assign blank     = (sw_kind_q == SW_INIT) ? BLANK_RESET : {color_q, CH_SPACE};

  // Cursor motion of a put: control characters, tab stops, wrap and bottom overflow.
  always_comb begin
    put_col   = {1'b0, cur_col_q};
    put_row   = {1'b0, cur_row_q};
    put_plain = 1'b0;
    put_ovf   = 1'b0;
    case (item_q.ch)
      CH_NEWLINE: begin
        put_col = '0;
        put_row = put_row + 1'b1;
      end
      CH_RETURN: put_col = '0;
      CH_TAB: begin
        put_col      = put_col + (CW+1)'(4);
        put_col[1:0] = 2'b00;
      end
      default: begin
        put_plain = 1'b1;
        put_col   = put_col + 1'b1;
      end
    endcase
    if (put_col >= ColsW) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    if (put_row >= RowsW) begin
      put_row = {1'b0, LastRow};
      put_ovf = 1'b1;
    end
  end

  // Write port: a pending sweep write has the port; otherwise put or erase.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {color_q, CH_SPACE};
    if (pend_q) begin
      wr_en   = 1'b1;
      wr_addr = pidx_q;
      wr_data = pcopy_q ? rdata_q : blank;
    end else if (cmd_i.put_exec && put_plain) begin
      wr_en   = 1'b1;
      wr_data = {color_q, item_q.ch};
    end else if (cmd_i.erase) begin
      wr_en   = 1'b1;
    end
  end

  // Read port: scroll copy source, backspace scan, or cell read.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_addr;
    if (copy_rd) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + ColsA;
    end else if (cmd_i.rd_cursor) begin
      rd_en   = 1'b1;
    end else if (cmd_i.rd_cell && in_range) begin
      rd_en   = 1'b1;
      rd_addr = item_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Cursor next value.
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (cmd_i.cur_home) begin
      cur_col_d = '0;
      cur_row_d = '0;
    end else if (cmd_i.put_exec) begin
      cur_col_d = put_col[CW-1:0];
      cur_row_d = put_row[RW-1:0];
    end else if (cmd_i.bs_begin) begin
      if (cur_col_q != '0) begin
        cur_col_d = cur_col_q - 1'b1;
      end else if (cur_row_q != '0) begin
        cur_row_d = cur_row_q - 1'b1;
        cur_col_d = LastCol;
      end
    end else if (cmd_i.scan_dec) begin
      cur_col_d = cur_col_q - 1'b1;
    end else if (cmd_i.bs_fix) begin
      cur_col_d = (cur_col_q == LastCol) ? cur_col_q : cur_col_q + 1'b1;
    end
  end

  // Control registers: cursor, color, sweep walk and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      color_q     <= COLOR_RESET;
      scr_q       <= 1'b0;
      sw_kind_q   <= SW_INIT;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        scr_q <= 1'b0;
      end else if (cmd_i.put_exec && put_ovf) begin
        scr_q <= 1'b1;
      end
      if (cmd_i.sweep_start) begin
        sw_kind_q <= cmd_i.sweep_kind;
        idx_q     <= '0;
      end else if (cmd_i.sweep_step) begin
        idx_q <= idx_q + 1'b1;
      end
      pend_q <= cmd_i.sweep_step;
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: latched item, pending sweep write, result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    pidx_q  <= idx_q;
    pcopy_q <= copy_rd;
    if (cmd_i.resp_load) begin
      out_item_q.cursor_col <= 7'(cur_col_q);
      out_item_q.cursor_row <= 5'(cur_row_q);
      out_item_q.scrolled   <= scr_q;
      out_item_q.cell_entry <= (item_q.op == OP_READ && in_range) ? rdata_q : 16'h0000;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.op         = item_q.op;
  assign status_o.put_ovf    = put_ovf;
  assign status_o.bs_scan    = (cur_col_q == '0) && (cur_row_q != '0);
  assign status_o.scan_space = (rdata_q[7:0] == CH_SPACE);
  assign status_o.col_is_one = (cur_col_q == CW'(1));
  assign status_o.sweep_last = (idx_q == LastA);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // The delayed sweep write never collides with a put or an erase.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(cmd_i.put_exec || cmd_i.erase))
    else $error("two writes to the screen buffer in one cycle");

  // The cursor always points inside the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < ColsW) && ({1'b0, cur_row_q} < RowsW))
    else $error("cursor outside the screen");

  // A scroll always leaves the cursor on the bottom row.
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scr_q |-> (cur_row_q == LastRow))
    else $error("scrolled without cursor on bottom row");

endmodule

// ===== hw/rtl/text_console_writer_unit.sv =====
// Character-cell text console of ROWS x COLS cells, each holding an attribute
// byte (high) and a character byte (low), with a cursor. After reset the block
// blanks the whole screen to 0x0F20, one cell per cycle; input items are not
// accepted until it ends, while color writes are taken at any time. A put that
// runs past the bottom row adds a scroll walk over the whole screen, and a
// clear also walks the whole screen. A backspace from column zero scans the
// previous row from its right end. The screen memory takes one write and one
// registered read per cycle, and the sweep counter walks it one cell per
// cycle. Each item gives one result, held in an output register, so the
// next item can be accepted while a result still waits to be taken.
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_chan_if.sink   in_i,
  tcw_chan_if.source out_o,
  tcw_chan_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;

  // The color register is always ready for a write.
  assign cfg_i.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
